// File: sv/atdc_pkg.sv
package atdc_pkg;

    localparam int ANGLE_W   = 16;
    localparam int CODE_W    = 16;
    localparam int FSD_W     = 11;
    localparam int DECI_W    = FSD_W + 1;
    localparam int SPAN_W    = CODE_W + 1;
    localparam int PROD_W    = SPAN_W + DECI_W;
    localparam int QUO_W     = CODE_W;
    localparam int REM_W     = FSD_W;
    localparam int MAG_W     = QUO_W + REM_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CODE_W-1:0] ZERO_CODE_RST  = 16'd32768;
    localparam logic [CODE_W-1:0] FULL_CODE_RST  = 16'd65535;
    localparam logic [FSD_W-1:0]  FULL_SCALE_RST = 11'd900;
    localparam logic [CODE_W-1:0] FAULT_CODE_RST = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_CODE       = 2'd0,
        REG_FULL_CODE       = 2'd1,
        REG_FULL_SCALE_DECI = 2'd2,
        REG_FAULT_CODE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CODE_W-1:0] zero_code;
        logic [CODE_W-1:0] full_code;
        logic [FSD_W-1:0]  full_scale_deci;
        logic [CODE_W-1:0] fault_code;
    } cfg_t;

    typedef struct packed {
        logic signed [DECI_W-1:0] deci;
        logic                     fault;
    } qent_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             fault;
    } div_t;

    function automatic logic [FSD_W-1:0] limit_of(input logic [FSD_W-1:0] fsd);
        return (fsd == '0) ? FSD_W'(1) : fsd;
    endfunction

endpackage

// File: sv/atdc_if.sv
interface angle_if;
    import atdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle_deci;
    logic                      angle_valid;

    modport source (output valid, output angle_deci, output angle_valid, input ready);
    modport sink (input valid, input angle_deci, input angle_valid, output ready);
endinterface

interface dac_if;
    import atdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic [CODE_W-1:0] mirror_code;
    logic              is_fault;

    modport source (output valid, output dac_code, output mirror_code, output is_fault,
                    input ready);
    modport sink (input valid, input dac_code, input mirror_code, input is_fault,
                  output ready);
endinterface

// File: sv/atdc_front.sv
module atdc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    angle_if.sink                          angle_in,
    input  logic                           cfg_we,
    input  logic [atdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atdc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           q_full,
    output logic                           q_push,
    output atdc_pkg::qent_t                q_data,
    output atdc_pkg::cfg_t                 cfg
);
    import atdc_pkg::*;

    cfg_t                    cfg_reg;
    logic [FSD_W-1:0]        lim;
    logic signed [ANGLE_W:0] lim_s;
    logic signed [ANGLE_W:0] ang_s;
    logic signed [ANGLE_W:0] clamp_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_code       <= ZERO_CODE_RST;
            cfg_reg.full_code       <= FULL_CODE_RST;
            cfg_reg.full_scale_deci <= FULL_SCALE_RST;
            cfg_reg.fault_code      <= FAULT_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ZERO_CODE:       cfg_reg.zero_code       <= cfg_wdata[CODE_W-1:0];
                REG_FULL_CODE:       cfg_reg.full_code       <= cfg_wdata[CODE_W-1:0];
                REG_FULL_SCALE_DECI: cfg_reg.full_scale_deci <= cfg_wdata[FSD_W-1:0];
                REG_FAULT_CODE:      cfg_reg.fault_code      <= cfg_wdata[CODE_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // clamp to +/- limit
    always_comb
    begin
        lim   = limit_of(cfg_reg.full_scale_deci);
        lim_s = $signed({{(ANGLE_W + 1 - FSD_W){1'b0}}, lim});
        ang_s = $signed({angle_in.angle_deci[ANGLE_W-1], angle_in.angle_deci});
        if (ang_s > lim_s)
        begin
            clamp_s = lim_s;
        end
        else if (ang_s < -lim_s)
        begin
            clamp_s = -lim_s;
        end
        else
        begin
            clamp_s = ang_s;
        end
    end

    assign q_data.deci    = clamp_s[DECI_W-1:0];
    assign q_data.fault   = !angle_in.angle_valid;
    assign angle_in.ready = !q_full;
    assign q_push         = angle_in.valid && !q_full;
    assign cfg            = cfg_reg;

endmodule

// File: sv/atdc_queue.sv
module atdc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  atdc_pkg::qent_t push_data,
    input  logic            pop,
    output atdc_pkg::qent_t head,
    output logic            empty,
    output logic            full
);
    import atdc_pkg::*;

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/atdc_back.sv
module atdc_back #(
    parameter int CODE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  atdc_pkg::cfg_t  cfg,
    input  atdc_pkg::qent_t head,
    input  logic            empty,
    output logic            pop,
    dac_if.source           code_out
);
    import atdc_pkg::*;

    localparam int unsigned MASK_INT = (1 << CODE_BITS) - 1;
    localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'(MASK_INT);

    logic                     adv;
    logic [FSD_W-1:0]         lim;
    logic [FSD_W-1:0]         half;
    logic signed [SPAN_W-1:0] span;
    logic signed [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0]        abs_p;
    logic [MAG_W-1:0]         mag;

    logic                     s0_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     s0_fault_reg;

    logic                     vld_reg [QUO_W+1];
    div_t                     div_reg [QUO_W+1];

    logic                     out_vld_reg;
    logic [CODE_W-1:0]        dac_reg;
    logic [CODE_W-1:0]        mirror_reg;
    logic                     fault_reg;

    logic [CODE_W-1:0]        off;
    logic [CODE_W-1:0]        sum;
    logic [CODE_W-1:0]        mirror;

    assign adv  = !out_vld_reg || code_out.ready;
    assign pop  = adv && !empty;
    assign lim  = limit_of(cfg.full_scale_deci);
    assign half = lim >> 1;
    assign span = $signed({1'b0, cfg.full_code}) - $signed({1'b0, cfg.zero_code});

    assign prod_next = span * head.deci;
    assign abs_p     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign mag       = abs_p[MAG_W-1:0] + MAG_W'(half);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            vld_reg[0]  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= !empty;
            vld_reg[0]  <= s0_vld_reg;
            out_vld_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg         <= prod_next;
            s0_fault_reg     <= head.fault;
            div_reg[0].rem   <= mag[MAG_W-1:QUO_W];
            div_reg[0].low   <= mag[QUO_W-1:0];
            div_reg[0].quo   <= '0;
            div_reg[0].neg   <= prod_reg[PROD_W-1];
            div_reg[0].fault <= s0_fault_reg;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_div
        logic [REM_W:0]   trial;
        logic [REM_W:0]   diff;
        logic             ge;
        div_t             step_next;

        always_comb
        begin
            trial           = {div_reg[k-1].rem, div_reg[k-1].low[QUO_W-1]};
            diff            = trial - {1'b0, lim};
            ge              = (trial >= {1'b0, lim});
            step_next.rem   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            step_next.low   = {div_reg[k-1].low[QUO_W-2:0], 1'b0};
            step_next.quo   = {div_reg[k-1].quo[QUO_W-2:0], ge};
            step_next.neg   = div_reg[k-1].neg;
            step_next.fault = div_reg[k-1].fault;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k] <= step_next;
            end
        end
    end

    always_comb
    begin
        off    = div_reg[QUO_W].neg ? (~div_reg[QUO_W].quo + 1'b1) : div_reg[QUO_W].quo;
        sum    = cfg.zero_code + off;
        mirror = {cfg.zero_code[CODE_W-2:0], 1'b0} - cfg.full_code;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dac_reg    <= (div_reg[QUO_W].fault ? cfg.fault_code : sum) & CODE_MASK;
            mirror_reg <= mirror & CODE_MASK;
            fault_reg  <= div_reg[QUO_W].fault;
        end
    end

    assign code_out.valid       = out_vld_reg;
    assign code_out.dac_code    = dac_reg;
    assign code_out.mirror_code = mirror_reg;
    assign code_out.is_fault    = fault_reg;

endmodule

// File: sv/angle_to_dac_code_scaler_unit.sv
// Angle to DAC code scaler. Each transfer on angle_in carries a signed angle in tenths of a
// degree; valid angles are clamped to +/- full_scale_deci, scaled by the span
// (full_code - zero_code), divided by full_scale_deci with round half away from zero and
// offset by zero_code, wrapped to CODE_BITS bits. Invalid angles return fault_code with
// is_fault set. Every result also carries mirror_code = 2*zero_code - full_code. One angle
// is taken per clock cycle while the queue is not full. Each input transfer passes through
// the 4-entry input queue into the multiply register, then the magnitude and rounding
// offset register, the restoring divider (one quotient bit per stage) and the output
// register. The queue absorbs output stalls so angle_in keeps accepting until four items
// wait. Write the configuration only while no item is in flight; full_scale_deci of 0
// acts as 1.
module angle_to_dac_code_scaler_unit #(
    parameter int CODE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    angle_if.sink                          angle_in,
    dac_if.source                          code_out,
    input  logic                           cfg_we,
    input  logic [atdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atdc_pkg::CFG_W-1:0]     cfg_wdata
);
    import atdc_pkg::*;

    cfg_t  cfg;
    qent_t q_data;
    qent_t q_head;
    logic  q_push;
    logic  q_pop;
    logic  q_empty;
    logic  q_full;

    atdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .angle_in  (angle_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data),
        .cfg       (cfg)
    );

    atdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    atdc_back #(
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .code_out (code_out)
    );

endmodule

// File: sv/atdc_checker.sv
module atdc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [atdc_pkg::CODE_W-1:0] dac_code,
    input logic [atdc_pkg::CODE_W-1:0] mirror_code,
    input logic                        is_fault
);
    import atdc_pkg::*;

    logic [5:0] pending_reg;
    logic [5:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + {5'd0, in_xfer} - {5'd0, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without an accepted input");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pending_reg >= 6'(QDEPTH))
        else $error("input stalled with queue not full");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dac_code)
            && $stable(mirror_code) && $stable(is_fault))
        else $error("stalled result changed");

endmodule

bind angle_to_dac_code_scaler_unit atdc_checker u_atdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (angle_in.valid),
    .in_ready    (angle_in.ready),
    .out_valid   (code_out.valid),
    .out_ready   (code_out.ready),
    .dac_code    (code_out.dac_code),
    .mirror_code (code_out.mirror_code),
    .is_fault    (code_out.is_fault)
);
